[src/bsc_pkg.sv]
// Package: shared types, codes and constants for the barometric compensation block.
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int SLOT_COUNT = 11;
    localparam int OSS_WIDTH  = 2;
    localparam logic [OSS_WIDTH-1:0] OSS_RESET = 2'd2;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TEMP  = 2'd1,
        ACT_PRESS = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // calibration slots
    localparam logic [3:0] SLOT_AC1 = 4'd0;
    localparam logic [3:0] SLOT_AC2 = 4'd1;
    localparam logic [3:0] SLOT_AC3 = 4'd2;
    localparam logic [3:0] SLOT_AC4 = 4'd3;
    localparam logic [3:0] SLOT_AC5 = 4'd4;
    localparam logic [3:0] SLOT_AC6 = 4'd5;
    localparam logic [3:0] SLOT_B1  = 4'd6;
    localparam logic [3:0] SLOT_B2  = 4'd7;
    localparam logic [3:0] SLOT_MC  = 4'd9;
    localparam logic [3:0] SLOT_MD  = 4'd10;

    // serial arithmetic unit commands
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_UDIV = 2'd1,
        OP_SDIV = 2'd2
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_P10, S_P11, S_P12, S_P13, S_P14,
        S_OUT
    } t_state;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

[src/bsc_alu.sv]
// Shared bit-serial unit: 32-bit wrapping multiply and restoring divide, one bit per cycle.
`timescale 1ns / 1ps
module bsc_alu
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    t_op         r_op, n_op;
    logic [31:0] r_acc, n_acc;   // product or remainder
    logic [31:0] r_a, n_a;       // multiplicand shifted left, or dividend shifted out
    logic [31:0] r_b, n_b;       // multiplier shifted right, or divisor magnitude
    logic [31:0] r_q, n_q;       // quotient
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [31:0] w_rem;

    always_comb begin
        w_rem   = {r_acc[30:0], r_a[31]};
        w_trial = {1'b0, w_rem} - {1'b0, r_b};
    end

    // step one bit per cycle
    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_op = r_op; n_acc = r_acc;
        n_a = r_a; n_b = r_b; n_q = r_q; n_neg = r_neg; n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_op   = i_req.op;
            n_acc  = '0;
            n_q    = '0;
            n_neg  = 1'b0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            if (i_req.op == OP_SDIV) begin
                n_neg = i_req.a[31] ^ i_req.b[31];
                n_a   = i_req.a[31] ? 32'(-i_req.a) : i_req.a;
                n_b   = i_req.b[31] ? 32'(-i_req.b) : i_req.b;
            end
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[30:0], 1'b0};
                n_b = {1'b0, r_b[31:1]};
            end else begin
                n_a = {r_a[30:0], 1'b0};
                if (!w_trial[32]) begin
                    n_acc = w_trial[31:0];
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_acc = w_rem;
                    n_q   = {r_q[30:0], 1'b0};
                end
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_op <= n_op; r_acc <= n_acc; r_a <= n_a;
        r_b <= n_b; r_q <= n_q; r_neg <= n_neg;
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            OP_MUL:  o_rsp.res = r_acc;
            OP_SDIV: o_rsp.res = r_neg ? 32'(-r_q) : r_q;
            default: o_rsp.res = r_q;
        endcase
    end

    // done pulses one cycle only
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("alu done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> r_busy) else $error("alu done without work");
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start && r_cnt != 6'd31 |=> r_busy)
        else $error("alu stopped early");

endmodule

[src/baro_sensor_compensation.sv]
// Top level: calibration table, sequencer and shared serial multiply/divide unit.
//
// Usage:
//   Input channel i_valid / o_stall carries one item: action, coeff_index,
//   coeff_value, raw_value. Output channel o_valid / i_stall returns one item
//   per accepted item with action 0..2 (action 3 is dropped silently).
//   Configuration port i_cfg_valid / o_cfg_ready writes the 2-bit
//   oversampling setting; it is always ready.
// Sequencing:
//   A load result is valid in the cycle after the item is taken. A temperature
//   item uses one multiply and one divide; a pressure item uses ten
//   multiplies and one divide. Each multiply or divide runs through the
//   shared bit-serial unit, which sets the rate.
//   One item is worked on at a time; o_stall is high while an item is in
//   progress and while its result waits.
// Reset:
//   i_rst_n low (synchronous) clears the table, b5, the sequencer and
//   sets oversampling to 2.
// Stall:
//   A result waits in the output register while i_stall is high; no new
//   item is taken until it leaves.
`timescale 1ns / 1ps
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_coeff_index,
    input  logic [15:0] i_coeff_value,
    input  logic [23:0] i_raw_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic signed [31:0] o_result_value,
    output logic        o_divide_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    logic [15:0] r_cal [SLOT_COUNT];
    logic [31:0] r_b5, n_b5;
    logic [OSS_WIDTH-1:0] r_oss;
    t_state      r_state, n_state;
    logic [1:0]  r_kind, n_kind;
    logic [23:0] r_raw, n_raw;
    logic [31:0] r_x1, n_x1, r_x2, n_x2, r_x3, n_x3, r_b6, n_b6, r_sq, n_sq;
    logic [31:0] r_b3, n_b3, r_b4, n_b4, r_p, n_p;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_oval, n_oval;
    logic        r_oerr, n_oerr;
    logic        r_wait, n_wait;
    t_alu_req    w_req;
    t_alu_rsp    w_rsp;
    logic        w_accept;
    logic [31:0] w_up, w_b7;
    logic [15:0] w_c50k;

    assign o_cfg_ready = 1'b1;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign w_accept = i_valid && !o_stall;

    bsc_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // hold oversampling setting and calibration table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= OSS_RESET;
            for (int k = 0; k < SLOT_COUNT; k++) r_cal[k] <= '0;
        end else begin
            if (i_cfg_valid) r_oss <= i_cfg_data;
            if (w_accept && i_action == ACT_LOAD && i_coeff_index < 4'(SLOT_COUNT))
                r_cal[i_coeff_index] <= i_coeff_value;
        end
    end

    always_comb begin
        w_up   = 32'({8'd0, r_raw} >> (4'd8 - {2'b0, r_oss}));
        w_c50k = 16'(16'd50000 >> r_oss);
        w_b7   = r_x3; // b7 is left in x3 by the sequencer
    end

    // sequencer: each step issues one serial op or a narrow update
    always_comb begin
        n_state = r_state; n_kind = r_kind; n_raw = r_raw;
        n_x1 = r_x1; n_x2 = r_x2; n_x3 = r_x3; n_b6 = r_b6; n_sq = r_sq;
        n_b3 = r_b3; n_b4 = r_b4; n_p = r_p; n_b5 = r_b5;
        n_ovalid = r_ovalid; n_oval = r_oval; n_oerr = r_oerr; n_wait = 1'b0;
        w_req = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind = i_action;
                    n_raw  = i_raw_value;
                    case (t_action'(i_action))
                        ACT_LOAD: begin
                            n_ovalid = 1'b1; n_oval = '0; n_oerr = 1'b0;
                        end
                        ACT_TEMP:  n_state = S_T0;
                        ACT_PRESS: n_state = S_P0;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            // x1 = (ut - ac6) * ac5 >> 15
            S_T0: begin
                w_req = '{start: 1'b1, op: OP_MUL,
                          a: {16'd0, r_raw[15:0]} - {16'd0, r_cal[SLOT_AC6]},
                          b: {16'd0, r_cal[SLOT_AC5]}};
                n_state = S_T1;
            end
            S_T1: if (w_rsp.done) begin
                n_x1 = asr32(w_rsp.res, 5'd15);
                n_x3 = asr32(w_rsp.res, 5'd15) + sx16(r_cal[SLOT_MD]);
                n_state = S_T2;
            end
            S_T2: begin
                if (r_x3 == '0) begin
                    n_ovalid = 1'b1; n_oval = '0; n_oerr = 1'b1; n_state = S_IDLE;
                end else begin
                    w_req = '{start: 1'b1, op: OP_SDIV,
                              a: sx16(r_cal[SLOT_MC]) << 11, b: r_x3};
                    n_state = S_T3;
                end
            end
            S_T3: if (w_rsp.done) begin
                n_b5 = r_x1 + w_rsp.res;
                n_ovalid = 1'b1; n_oerr = 1'b0;
                n_oval = asr32(r_x1 + w_rsp.res + 32'd8, 5'd4);
                n_state = S_IDLE;
            end
            // b6 and b6*b6
            S_P0: begin
                n_b6 = r_b5 - 32'd4000;
                w_req = '{start: 1'b1, op: OP_MUL, a: r_b5 - 32'd4000, b: r_b5 - 32'd4000};
                n_state = S_P1;
            end
            S_P1: if (w_rsp.done) begin
                n_sq = asr32(w_rsp.res, 5'd12);
                w_req = '{start: 1'b1, op: OP_MUL, a: sx16(r_cal[SLOT_B2]),
                          b: asr32(w_rsp.res, 5'd12)};
                n_state = S_P2;
            end
            S_P2: if (w_rsp.done) begin
                n_x1 = asr32(w_rsp.res, 5'd11);
                w_req = '{start: 1'b1, op: OP_MUL, a: sx16(r_cal[SLOT_AC2]), b: r_b6};
                n_state = S_P3;
            end
            S_P3: if (w_rsp.done) begin
                n_b3 = asr32((((sx16(r_cal[SLOT_AC1]) << 2) + r_x1 +
                       asr32(w_rsp.res, 5'd11)) << r_oss) + 32'd2, 5'd2);
                w_req = '{start: 1'b1, op: OP_MUL, a: sx16(r_cal[SLOT_AC3]), b: r_b6};
                n_state = S_P4;
            end
            S_P4: if (w_rsp.done) begin
                n_x1 = asr32(w_rsp.res, 5'd13);
                w_req = '{start: 1'b1, op: OP_MUL, a: sx16(r_cal[SLOT_B1]), b: r_sq};
                n_state = S_P5;
            end
            S_P5: if (w_rsp.done) begin
                n_x3 = asr32(r_x1 + asr32(w_rsp.res, 5'd16) + 32'd2, 5'd2);
                n_state = S_P6;
            end
            S_P6: begin
                w_req = '{start: 1'b1, op: OP_MUL, a: {16'd0, r_cal[SLOT_AC4]},
                          b: r_x3 + 32'd32768};
                n_state = S_P7;
            end
            S_P7: if (w_rsp.done) begin
                n_b4 = w_rsp.res >> 15;
                w_req = '{start: 1'b1, op: OP_MUL, a: w_up - r_b3, b: {16'd0, w_c50k}};
                n_state = S_P8;
            end
            S_P8: if (w_rsp.done) begin
                n_x3 = w_rsp.res;
                n_state = S_P9;
            end
            S_P9: begin
                if (r_b4 == '0) begin
                    n_ovalid = 1'b1; n_oval = '0; n_oerr = 1'b1; n_state = S_IDLE;
                end else begin
                    w_req = '{start: 1'b1, op: OP_UDIV,
                              a: w_b7[31] ? w_b7 : {w_b7[30:0], 1'b0}, b: r_b4};
                    n_state = S_P10;
                end
            end
            S_P10: if (w_rsp.done) begin
                n_p = w_b7[31] ? {w_rsp.res[30:0], 1'b0} : w_rsp.res;
                w_req = '{start: 1'b1, op: OP_MUL,
                          a: asr32(w_b7[31] ? {w_rsp.res[30:0], 1'b0} : w_rsp.res, 5'd8),
                          b: asr32(w_b7[31] ? {w_rsp.res[30:0], 1'b0} : w_rsp.res, 5'd8)};
                n_state = S_P11;
            end
            S_P11: if (w_rsp.done) begin
                w_req = '{start: 1'b1, op: OP_MUL, a: w_rsp.res, b: 32'd3038};
                n_state = S_P12;
            end
            S_P12: if (w_rsp.done) begin
                n_x1 = asr32(w_rsp.res, 5'd16);
                w_req = '{start: 1'b1, op: OP_MUL, a: 32'(-32'sd7357), b: r_p};
                n_state = S_P13;
            end
            S_P13: if (w_rsp.done) begin
                n_x2 = asr32(w_rsp.res, 5'd16);
                n_state = S_P14;
            end
            S_P14: begin
                n_ovalid = 1'b1; n_oerr = 1'b0;
                n_oval = r_p + asr32(r_x1 + r_x2 + 32'd3791, 5'd4);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_OUT) n_state = S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_b5     <= '0;
            r_wait   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_b5     <= n_b5;
            r_wait   <= n_wait;
        end
        r_kind <= n_kind; r_raw <= n_raw; r_x1 <= n_x1; r_x2 <= n_x2; r_x3 <= n_x3;
        r_b6 <= n_b6; r_sq <= n_sq; r_b3 <= n_b3; r_b4 <= n_b4; r_p <= n_p;
        r_oval <= n_oval; r_oerr <= n_oerr;
    end

    assign o_valid        = r_ovalid;
    assign o_result_kind  = r_kind;
    assign o_result_value = $signed(r_oval);
    assign o_divide_error = r_oerr & ~r_wait;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !w_accept) else $error("item taken while busy");
    a_result_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_state == S_IDLE) else $error("result outside idle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oerr |-> r_oval == '0) else $error("error with value");

endmodule
